>>> rtl/wcum_pkg.sv
`timescale 1ns / 1ps

package wcum_pkg;

	localparam int TIME_W   = 64;
	localparam int INDEX_W  = 4;
	localparam int WLEN_W   = 5;
	localparam int USAGE_W  = 14;
	localparam int STATUS_W = 2;
	localparam int SNAP_W   = 5 * TIME_W;
	// busy and total are sums of up to four 64-bit deltas
	localparam int SUM_W    = TIME_W + 2;
	// busy * 10000 stays below 2^80
	localparam int NUM_W    = SUM_W + USAGE_W;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd16;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
	localparam int MUL_STEPS = 5;
	localparam int DIV_STEPS = USAGE_W;
	localparam int STEP_W    = 4;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_POS    = 2'd1,
		STATUS_ZERO_TOTAL = 2'd2
	} wcum_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RD_B,
		ST_DIFF,
		ST_SUM1,
		ST_SUM2,
		ST_SUM3,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} wcum_state_t;

	typedef struct packed {
		logic               accept;
		logic               rd_b;
		logic               cap_a;
		logic               diff;
		logic               sum1;
		logic               sum2;
		logic               sum3;
		logic               mul;
		logic               div;
		logic [STEP_W-1:0]  step;
		logic               load_out;
		wcum_status_t       res_status;
	} wcum_cmd_t;

	typedef struct packed {
		logic pos_ok;
		logic total_zero;
	} wcum_stat_t;

	function automatic logic [3:0] mul_shift(input logic [STEP_W-1:0] step);
		logic [3:0] sh;
		case (step)
			4'd0:    sh = 4'd13;
			4'd1:    sh = 4'd10;
			4'd2:    sh = 4'd9;
			4'd3:    sh = 4'd8;
			default: sh = 4'd4;
		endcase
		return sh;
	endfunction

endpackage

>>> rtl/wcum_if.sv
`timescale 1ns / 1ps

interface wcum_req_if;
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic [wcum_pkg::TIME_W-1:0]    user_time;
	logic [wcum_pkg::TIME_W-1:0]    user_low_time;
	logic [wcum_pkg::TIME_W-1:0]    system_time;
	logic [wcum_pkg::TIME_W-1:0]    idle_time;
	logic [wcum_pkg::TIME_W-1:0]    tick_stamp;
	logic [wcum_pkg::INDEX_W-1:0]   first_index;
	logic [wcum_pkg::INDEX_W-1:0]   second_index;

	modport source (
		output valid, op, user_time, user_low_time, system_time, idle_time, tick_stamp,
		       first_index, second_index,
		input  ready
	);
	modport sink (
		input  valid, op, user_time, user_low_time, system_time, idle_time, tick_stamp,
		       first_index, second_index,
		output ready
	);
endinterface

interface wcum_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [wcum_pkg::STATUS_W-1:0]  status;
	logic [wcum_pkg::USAGE_W-1:0]   usage_hundredths;
	logic [wcum_pkg::TIME_W-1:0]    elapsed_ticks;

	modport source (
		output valid, status, usage_hundredths, elapsed_ticks,
		input  ready
	);
	modport sink (
		input  valid, status, usage_hundredths, elapsed_ticks,
		output ready
	);
endinterface

>>> rtl/wcum_ram.sv
`timescale 1ns / 1ps

module wcum_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

>>> rtl/wcum_ctrl.sv
`timescale 1ns / 1ps

module wcum_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  wcum_pkg::wcum_stat_t stat,
	output wcum_pkg::wcum_cmd_t  cmd
);
	import wcum_pkg::*;

	wcum_state_t       state_q, state_d;
	wcum_status_t      code_q, code_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              rsp_valid_q, rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			code_q      <= STATUS_OK;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			code_q      <= code_d;
			cnt_q       <= cnt_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		code_d         = code_q;
		cnt_d          = cnt_q;
		cmd            = '0;
		cmd.step       = cnt_q;
		cmd.res_status = code_q;
		req_ready      = 1'b0;

		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// first read address goes out here when positions are good
				if (stat.pos_ok) begin
					code_d  = STATUS_OK;
					state_d = ST_RD_B;
				end else begin
					code_d  = STATUS_BAD_POS;
					state_d = ST_OUT;
				end
			end
			ST_RD_B: begin
				cmd.rd_b  = 1'b1;
				cmd.cap_a = 1'b1;
				state_d   = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_SUM1;
			end
			ST_SUM1: begin
				cmd.sum1 = 1'b1;
				state_d  = ST_SUM2;
			end
			ST_SUM2: begin
				cmd.sum2 = 1'b1;
				state_d  = ST_SUM3;
			end
			ST_SUM3: begin
				cmd.sum3 = 1'b1;
				cnt_d    = '0;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				if (stat.total_zero) begin
					code_d  = STATUS_ZERO_TOTAL;
					cnt_d   = '0;
					state_d = ST_OUT;
				end else begin
					cmd.mul = 1'b1;
					if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
						cnt_d   = '0;
						state_d = ST_DIV;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_OUT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_OUT: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp_valid_d = rsp_valid_q;
		if (cmd.load_out) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_d = 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

>>> rtl/wcum_dp.sv
`timescale 1ns / 1ps

module wcum_dp #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wcum_pkg::WLEN_W-1:0]     cfg_wdata,
	input  logic                            op,
	input  logic [wcum_pkg::TIME_W-1:0]     user_time,
	input  logic [wcum_pkg::TIME_W-1:0]     user_low_time,
	input  logic [wcum_pkg::TIME_W-1:0]     system_time,
	input  logic [wcum_pkg::TIME_W-1:0]     idle_time,
	input  logic [wcum_pkg::TIME_W-1:0]     tick_stamp,
	input  logic [wcum_pkg::INDEX_W-1:0]    first_index,
	input  logic [wcum_pkg::INDEX_W-1:0]    second_index,
	input  wcum_pkg::wcum_cmd_t             cmd,
	output wcum_pkg::wcum_stat_t            stat,
	output logic [wcum_pkg::STATUS_W-1:0]   status,
	output logic [wcum_pkg::USAGE_W-1:0]    usage_hundredths,
	output logic [wcum_pkg::TIME_W-1:0]     elapsed_ticks
);
	import wcum_pkg::*;

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int PW = (CW > INDEX_W) ? CW : INDEX_W;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
	                                           input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(MAX_WINDOW)) begin
			sum = sum - (CW+1)'(MAX_WINDOW);
		end
		return AW'(sum);
	endfunction

	logic [WLEN_W-1:0]  wlen_q;
	logic [AW-1:0]      oldest_q;
	logic [CW-1:0]      fill_q;
	logic [PW-1:0]      p1_q, p2_q;

	logic [CW-1:0]      eff_len;
	logic               full;
	logic [CW-1:0]      drop;
	logic [AW-1:0]      oldest_n;
	logic [CW-1:0]      fill_mid;
	logic [AW-1:0]      slot_w, slot_a, slot_b;

	logic [SNAP_W-1:0]  rdata;
	logic [SNAP_W-1:0]  a_q;
	logic [TIME_W-1:0]  d_user_q, d_low_q, d_sys_q, d_idle_q, d_tick_q;
	logic [SUM_W-1:0]   busy_q, total_q;
	logic [NUM_W-1:0]   num_q, dsh_q;
	logic [USAGE_W-1:0] quo_q;
	logic               ge;

	wcum_status_t       status_q;
	logic [USAGE_W-1:0] usage_q;
	logic [TIME_W-1:0]  elapsed_q;

	// window length register; zero acts as one, large values clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
		end else if (cfg_we) begin
			wlen_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (wlen_q == '0) begin
			eff_len = CW'(1);
		end else if (32'(wlen_q) > MAX_WINDOW) begin
			eff_len = CW'(MAX_WINDOW);
		end else begin
			eff_len = CW'(wlen_q);
		end
		full     = fill_q >= eff_len;
		drop     = fill_q - eff_len + CW'(1);
		oldest_n = full ? wrap_add(oldest_q, drop) : oldest_q;
		fill_mid = full ? eff_len - CW'(1) : fill_q;
		slot_w   = wrap_add(oldest_n, fill_mid);
		slot_a   = wrap_add(oldest_q, CW'(p1_q));
		slot_b   = wrap_add(oldest_q, CW'(p2_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q   <= '0;
		end else if (cmd.accept && op == OP_ADD) begin
			oldest_q <= oldest_n;
			fill_q   <= fill_mid + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (op == OP_ADD) begin
				p1_q <= '0;
				p2_q <= PW'(fill_mid);
			end else begin
				p1_q <= PW'(first_index);
				p2_q <= PW'(second_index);
			end
		end
	end

	assign stat.pos_ok = (p1_q < PW'(fill_q)) && (p2_q < PW'(fill_q)) &&
	                     (p1_q < PW'(eff_len)) && (p2_q < PW'(eff_len)) &&
	                     (p1_q != p2_q);
	assign stat.total_zero = (total_q == '0);

	wcum_ram #(
		.WIDTH (SNAP_W),
		.DEPTH (MAX_WINDOW)
	) u_snap_ram (
		.clk     (clk),
		.we      (cmd.accept && op == OP_ADD),
		.waddr   (slot_w),
		.wdata   ({user_time, user_low_time, system_time, idle_time, tick_stamp}),
		.raddr   (cmd.rd_b ? slot_b : slot_a),
		.rdata_q (rdata)
	);

	assign ge = num_q >= dsh_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			a_q <= rdata;
		end
		if (cmd.diff) begin
			d_user_q <= rdata[4*TIME_W +: TIME_W] - a_q[4*TIME_W +: TIME_W];
			d_low_q  <= rdata[3*TIME_W +: TIME_W] - a_q[3*TIME_W +: TIME_W];
			d_sys_q  <= rdata[2*TIME_W +: TIME_W] - a_q[2*TIME_W +: TIME_W];
			d_idle_q <= rdata[1*TIME_W +: TIME_W] - a_q[1*TIME_W +: TIME_W];
			d_tick_q <= rdata[0 +: TIME_W]        - a_q[0 +: TIME_W];
		end
		if (cmd.sum1) begin
			busy_q <= SUM_W'(d_user_q) + SUM_W'(d_low_q);
		end
		if (cmd.sum2) begin
			busy_q <= busy_q + SUM_W'(d_sys_q);
		end
		if (cmd.sum3) begin
			total_q <= busy_q + SUM_W'(d_idle_q);
			num_q   <= '0;
		end
		// busy * 10000 by shift and add
		if (cmd.mul) begin
			num_q <= num_q + (NUM_W'(busy_q) << mul_shift(cmd.step));
			dsh_q <= NUM_W'(total_q) << (DIV_STEPS - 1);
		end
		// restoring division, one quotient bit per cycle, MSB first
		if (cmd.div) begin
			if (ge) begin
				num_q <= num_q - dsh_q;
			end
			quo_q <= {quo_q[USAGE_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.load_out) begin
			status_q  <= cmd.res_status;
			usage_q   <= (cmd.res_status == STATUS_OK) ? quo_q : '0;
			elapsed_q <= (cmd.res_status == STATUS_BAD_POS) ? '0 : d_tick_q;
		end
	end

	assign status           = status_q;
	assign usage_hundredths = usage_q;
	assign elapsed_ticks    = elapsed_q;

endmodule

>>> rtl/windowed_cpu_utilization_monitor.sv
`timescale 1ns / 1ps

// Windowed CPU utilization monitor. Keeps up to MAX_WINDOW cumulative counter
// snapshots (user, low-priority user, system, idle, tick stamp) in a circular
// window whose length is set by the window length register (0 acts as 1,
// values above MAX_WINDOW clamp). An add transfer stores a snapshot, dropping
// the oldest ones as needed, and reports utilization from the oldest to the
// newest entry; a query transfer reports between two positions (0 = oldest).
// Each request gives exactly one response: status 0 ok, 1 bad or equal
// positions, 2 zero total delta; usage in hundredths of a percent (truncated)
// and the tick delta, all deltas modulo 2^64. Timing: one item in flight at a
// time. A good request passes through memory reads and delta sums, shift-add
// scaling by 10000 and a 14-step restoring divider before the response is
// loaded; a zero-total result skips the scaling and the divider, and a bad
// position skips all of them. The response sits in its own register, so the
// next request is taken while it waits; write the window length only while
// idle.
module windowed_cpu_utilization_monitor #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wcum_pkg::WLEN_W-1:0]  cfg_wdata,
	wcum_req_if.sink                     req,
	wcum_rsp_if.source                   rsp
);
	import wcum_pkg::*;

	wcum_cmd_t  cmd;
	wcum_stat_t stat;

	// sequencer: steps one item through check, read, sum, scale, divide
	wcum_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// window storage, pointers and the arithmetic
	wcum_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.op               (req.op),
		.user_time        (req.user_time),
		.user_low_time    (req.user_low_time),
		.system_time      (req.system_time),
		.idle_time        (req.idle_time),
		.tick_stamp       (req.tick_stamp),
		.first_index      (req.first_index),
		.second_index     (req.second_index),
		.cmd              (cmd),
		.stat             (stat),
		.status           (rsp.status),
		.usage_hundredths (rsp.usage_hundredths),
		.elapsed_ticks    (rsp.elapsed_ticks)
	);

endmodule
